[hdl/hqst_pkg.sv]
// Shared types, character codes and the percent-escape decoder for the query tokenizer.
`default_nettype none

package hqst_pkg;

    typedef logic [2:0] kind_t;

    localparam kind_t KIND_PATH    = 3'd0;
    localparam kind_t KIND_NAME    = 3'd1;
    localparam kind_t KIND_VALUE   = 3'd2;
    localparam kind_t KIND_CLOSE   = 3'd3;
    localparam kind_t KIND_RESTART = 3'd4;

    localparam logic [7:0] CH_NUL     = 8'h00;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_LF      = 8'h0A;
    localparam logic [7:0] CH_VT      = 8'h0B;
    localparam logic [7:0] CH_FF      = 8'h0C;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_AMP     = 8'h26;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;
    localparam logic [7:0] CH_QUEST   = 8'h3F;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    function automatic hex_t hex_digit(input logic [7:0] c);
        hex_t r;
        r.ok  = 1'b1;
        r.val = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            r.val = 4'(c - 8'h30);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            r.val = 4'(c - 8'h57);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            r.val = 4'(c - 8'h37);
        end
        else
        begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    // Follows base-16 string conversion over exactly two characters.
    function automatic logic [7:0] hex_decode(input logic [7:0] c0, input logic [7:0] c1);
        hex_t       a;
        hex_t       b;
        logic [7:0] r;
        a = hex_digit(c0);
        b = hex_digit(c1);
        r = 8'd0;
        if (c0 == CH_TAB || c0 == CH_LF || c0 == CH_VT || c0 == CH_FF || c0 == CH_CR)
        begin
            r = b.ok ? {4'd0, b.val} : 8'd0;
        end
        else if (c0 == CH_PLUS)
        begin
            r = b.ok ? {4'd0, b.val} : 8'd0;
        end
        else if (c0 == CH_MINUS)
        begin
            r = b.ok ? 8'(8'd0 - {4'd0, b.val}) : 8'd0;
        end
        else if (a.ok)
        begin
            r = b.ok ? {a.val, b.val} : {4'd0, a.val};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[hdl/http_query_string_tokenizer.sv]
// Top level of the request-line query tokenizer with percent decoding.
// Output: a result is registered and appears on the master side in the cycle after its byte is accepted.
// Throughput: one byte per cycle while s_tready is high; the byte is classified by logic ahead of the result register.
// The slave side stays ready while the result register is empty or being drained.
// Reset: asynchronous active-low rst_n clears the parser state and empties the result register.
// A byte flagged by start_req restarts the parser before that byte is handled.
`default_nettype none

module http_query_string_tokenizer #(
    parameter int PATH_MAX    = 128,
    parameter int FIELD_MAX   = 20,
    parameter int PREFIX_SKIP = 4
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,   // [7:0] byte_in
    input  wire logic       s_tuser,   // [0] start_req
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic      [7:0] m_tdata,   // [7:0] data
    output logic      [2:0] m_tuser,   // [2:0] kind
    output logic            m_tlast    // final_res
);

    typedef enum logic [1:0] {
        PH_PATH  = 2'd0,
        PH_NAME  = 2'd1,
        PH_VALUE = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        PCT_IDLE = 2'd0,
        PCT_SEEN = 2'd1,
        PCT_HELD = 2'd2
    } pct_t;

    phase_t           phase_reg, phase_next, phase_cur;
    pct_t             pct_reg, pct_next, pct_cur;
    logic       [2:0] skip_reg, skip_next, skip_cur;
    logic             done_reg, done_next, done_cur;
    logic       [7:0] hex_reg, hex_next, hex_cur;
    logic       [7:0] path_len_reg, path_len_next, path_len_cur;
    logic       [5:0] name_len_reg, name_len_next, name_len_cur;
    logic       [5:0] value_len_reg, value_len_next, value_len_cur;

    logic             out_valid_reg, out_valid_next;
    logic       [7:0] out_data_reg, out_data_next;
    hqst_pkg::kind_t  out_kind_reg, out_kind_next;
    logic             out_last_reg, out_last_next;

    logic             accept;
    logic             emit;
    hqst_pkg::kind_t  emit_kind;
    logic       [7:0] emit_data;
    logic             emit_last;
    logic       [7:0] b;

    assign s_tready = !out_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign b        = s_tdata;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        if (s_tuser)
        begin
            phase_cur     = PH_PATH;
            pct_cur       = PCT_IDLE;
            skip_cur      = 3'd0;
            done_cur      = 1'b0;
            hex_cur       = 8'd0;
            path_len_cur  = 8'd0;
            name_len_cur  = 6'd0;
            value_len_cur = 6'd0;
        end
        else
        begin
            phase_cur     = phase_reg;
            pct_cur       = pct_reg;
            skip_cur      = skip_reg;
            done_cur      = done_reg;
            hex_cur       = hex_reg;
            path_len_cur  = path_len_reg;
            name_len_cur  = name_len_reg;
            value_len_cur = value_len_reg;
        end
    end

    always_comb
    begin
        phase_next     = phase_cur;
        pct_next       = pct_cur;
        skip_next      = skip_cur;
        done_next      = done_cur;
        hex_next       = hex_cur;
        path_len_next  = path_len_cur;
        name_len_next  = name_len_cur;
        value_len_next = value_len_cur;
        emit           = 1'b0;
        emit_kind      = hqst_pkg::KIND_PATH;
        emit_data      = 8'd0;
        emit_last      = 1'b0;

        if (!done_cur)
        begin
            if (b == hqst_pkg::CH_NUL)
            begin
                done_next = 1'b1;
            end
            else if (skip_cur < 3'(PREFIX_SKIP))
            begin
                skip_next = skip_cur + 3'd1;
            end
            else if (b == hqst_pkg::CH_SPACE)
            begin
                done_next = 1'b1;
                emit      = 1'b1;
                emit_kind = hqst_pkg::KIND_CLOSE;
                emit_last = 1'b1;
            end
            else if (phase_cur == PH_PATH)
            begin
                if (b == hqst_pkg::CH_QUEST)
                begin
                    phase_next = PH_NAME;
                end
                else if (path_len_cur < 8'(PATH_MAX)
                         && (path_len_cur != 8'd0 || b != hqst_pkg::CH_SLASH))
                begin
                    path_len_next = path_len_cur + 8'd1;
                    emit          = 1'b1;
                    emit_kind     = hqst_pkg::KIND_PATH;
                    emit_data     = b;
                end
            end
            else if (b == hqst_pkg::CH_EQUALS)
            begin
                value_len_next = 6'd0;
                phase_next     = PH_VALUE;
                emit           = 1'b1;
                emit_kind      = hqst_pkg::KIND_RESTART;
            end
            else if (b == hqst_pkg::CH_AMP)
            begin
                name_len_next = 6'd0;
                phase_next    = PH_NAME;
                emit          = 1'b1;
                emit_kind     = hqst_pkg::KIND_CLOSE;
            end
            else if (phase_cur == PH_NAME)
            begin
                if (name_len_cur < 6'(FIELD_MAX))
                begin
                    name_len_next = name_len_cur + 6'd1;
                    emit          = 1'b1;
                    emit_kind     = hqst_pkg::KIND_NAME;
                    emit_data     = b;
                end
            end
            else if (value_len_cur < 6'(FIELD_MAX))
            begin
                if (b == hqst_pkg::CH_PERCENT)
                begin
                    pct_next = PCT_SEEN;
                end
                else if (pct_cur == PCT_SEEN)
                begin
                    hex_next = b;
                    pct_next = PCT_HELD;
                end
                else
                begin
                    pct_next       = PCT_IDLE;
                    value_len_next = value_len_cur + 6'd1;
                    emit           = 1'b1;
                    emit_kind      = hqst_pkg::KIND_VALUE;
                    emit_data      = (pct_cur == PCT_HELD)
                                     ? hqst_pkg::hex_decode(hex_cur, b) : b;
                end
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_kind_next  = out_kind_reg;
        out_last_next  = out_last_reg;
        if (accept && emit)
        begin
            out_valid_next = 1'b1;
            out_data_next  = emit_data;
            out_kind_next  = emit_kind;
            out_last_next  = emit_last;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_PATH;
            pct_reg       <= PCT_IDLE;
            skip_reg      <= 3'd0;
            done_reg      <= 1'b0;
            hex_reg       <= 8'd0;
            path_len_reg  <= 8'd0;
            name_len_reg  <= 6'd0;
            value_len_reg <= 6'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg     <= phase_next;
                pct_reg       <= pct_next;
                skip_reg      <= skip_next;
                done_reg      <= done_next;
                hex_reg       <= hex_next;
                path_len_reg  <= path_len_next;
                name_len_reg  <= name_len_next;
                value_len_reg <= value_len_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        out_kind_reg <= out_kind_next;
        out_last_reg <= out_last_next;
    end

`ifndef SYNTHESIS
    a_final_is_close: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser == hqst_pkg::KIND_CLOSE && m_tdata == 8'd0)
        else $error("End of line must be a closing marker with zero data.");

    a_final_sets_done: assert property (@(posedge clk) disable iff (!rst_n)
        accept && emit && emit_last |=> done_reg)
        else $error("Ending the line must set the done flag.");

    a_lengths_capped: assert property (@(posedge clk) disable iff (!rst_n)
        path_len_reg <= 8'(PATH_MAX) && name_len_reg <= 6'(FIELD_MAX)
        && value_len_reg <= 6'(FIELD_MAX))
        else $error("A field length exceeded its cap.");

    a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
        accept && done_reg && !s_tuser |-> !emit)
        else $error("A result was produced after the end of the line.");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("Input stalled while the result register was empty.");
`endif

endmodule

`default_nettype wire
